FILE: sv/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside of reset.
`define LOGRID_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("logrid assertion failed");

// Expression must never be true outside of reset.
`define LOGRID_ASSERT_NEVER(lbl, clk, rst_n, expr) \
    `LOGRID_ASSERT(lbl, clk, rst_n, !(expr))

`endif

FILE: sv/logrid_pkg.sv
`default_nettype none

package logrid_pkg;

    typedef enum logic [1:0] {
        OP_FREE     = 2'd0,
        OP_OCCUPIED = 2'd1,
        OP_PRIOR    = 2'd2,
        OP_QUERY    = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        CS_UNKNOWN  = 2'd0,
        CS_FREE     = 2'd1,
        CS_OCCUPIED = 2'd2
    } t_occ_state;

    typedef enum logic [1:0] {
        ST_CLEAR  = 2'd0,
        ST_IDLE   = 2'd1,
        ST_READ   = 2'd2,
        ST_MODIFY = 2'd3
    } t_state;

    // Register index, i.e. paddr[4:2]
    typedef enum logic [2:0] {
        CFG_GRID_WIDTH      = 3'd0,
        CFG_GRID_HEIGHT     = 3'd1,
        CFG_KNOWN_THRESHOLD = 3'd2,
        CFG_FREE_STEP       = 3'd3,
        CFG_OCCUPIED_STEP   = 3'd4,
        CFG_LOWER_LIMIT     = 3'd5,
        CFG_UPPER_LIMIT     = 3'd6
    } t_cfg_reg;

    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;

    localparam logic [8:0]         RST_GRID_WIDTH      = 9'd256;
    localparam logic [8:0]         RST_GRID_HEIGHT     = 9'd256;
    localparam logic [14:0]        RST_KNOWN_THRESHOLD = 15'd256;
    localparam logic signed [15:0] RST_FREE_STEP       = -16'sd102;
    localparam logic [14:0]        RST_OCCUPIED_STEP   = 15'd218;
    localparam logic signed [15:0] RST_LOWER_LIMIT     = -16'sd1280;
    localparam logic signed [15:0] RST_UPPER_LIMIT     = 16'sd1280;

endpackage

`default_nettype wire

FILE: sv/logrid_ifs.sv
`default_nettype none

interface logrid_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         op;
    logic signed [15:0] cell_x;
    logic signed [15:0] cell_y;
    logic               prior_occupied;
    logic [14:0]        prior_strength;
    logic               unknown_as_occupied;

    modport source (
        output valid, op, cell_x, cell_y, prior_occupied, prior_strength,
               unknown_as_occupied,
        input  ready
    );
    modport sink (
        input  valid, op, cell_x, cell_y, prior_occupied, prior_strength,
               unknown_as_occupied,
        output ready
    );
endinterface

interface logrid_rsp_if;
    logic               valid;
    logic               ready;
    logic               inside_res;
    logic               observed;
    logic signed [15:0] cell_log_odds;
    logic [1:0]         occ_state;
    logic               binary_state;
    logic               prior_error;

    modport source (
        output valid, inside_res, observed, cell_log_odds, occ_state,
               binary_state, prior_error,
        input  ready
    );
    modport sink (
        input  valid, inside_res, observed, cell_log_odds, occ_state,
               binary_state, prior_error,
        output ready
    );
endinterface

`default_nettype wire

FILE: sv/log_odds_occupancy_grid_unit.sv
// Each accepted item goes through accept, memory read, and modify + write back
// in the single cell memory with its registered read port; input ready is low
// until that item is done, and modify waits while the result register is full.
// Reset: config registers return to their defaults, then a clear sweep over
// all MAX_WIDTH*MAX_HEIGHT cells zeroes the cell memory with input ready low.
`default_nettype none

module log_odds_occupancy_grid_unit #(
    parameter int MAX_WIDTH     = 256,
    parameter int MAX_HEIGHT    = 256,
    parameter int LOG_ODDS_BITS = 16
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    logrid_req_if.sink                                  i_req,
    logrid_rsp_if.source                                o_rsp,
    input  wire logic                                   psel,
    input  wire logic                                   penable,
    input  wire logic                                   pwrite,
    input  wire logic [logrid_pkg::CFG_ADDR_W-1:0]      paddr,
    input  wire logic [logrid_pkg::CFG_DATA_W-1:0]      pwdata,
    output logic      [logrid_pkg::CFG_DATA_W-1:0]      prdata,
    output logic                                        pready
);

    localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(CELLS);
    localparam int XB    = $clog2(MAX_WIDTH);
    localparam int YB    = $clog2(MAX_HEIGHT);
    localparam int WB    = $clog2(MAX_WIDTH + 1);
    localparam int HB    = $clog2(MAX_HEIGHT + 1);
    localparam int CWW   = (WB > 9) ? WB : 9;
    localparam int CWH   = (HB > 9) ? HB : 9;
    localparam int CMPW  = ((CWW > CWH) ? CWW : CWH) + 16;
    localparam int PW    = YB + CWW;
    localparam int IW    = PW + 1;
    localparam int LB    = LOG_ODDS_BITS;
    localparam int EW    = ((LB > 16) ? LB : 16) + 2;

    localparam logic signed [EW-1:0] SMAX = {{(EW-LB+1){1'b0}}, {(LB-1){1'b1}}};
    localparam logic signed [EW-1:0] SMIN = {{(EW-LB+1){1'b1}}, {(LB-1){1'b0}}};

    // ---------------- configuration registers ----------------
    logic [8:0]         r_grid_width;
    logic [8:0]         r_grid_height;
    logic [14:0]        r_known_threshold;
    logic signed [15:0] r_free_step;
    logic [14:0]        r_occupied_step;
    logic signed [15:0] r_lower_limit;
    logic signed [15:0] r_upper_limit;

    logic                 cfg_wr;
    logrid_pkg::t_cfg_reg cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = logrid_pkg::t_cfg_reg'(paddr[logrid_pkg::CFG_ADDR_W-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width      <= logrid_pkg::RST_GRID_WIDTH;
            r_grid_height     <= logrid_pkg::RST_GRID_HEIGHT;
            r_known_threshold <= logrid_pkg::RST_KNOWN_THRESHOLD;
            r_free_step       <= logrid_pkg::RST_FREE_STEP;
            r_occupied_step   <= logrid_pkg::RST_OCCUPIED_STEP;
            r_lower_limit     <= logrid_pkg::RST_LOWER_LIMIT;
            r_upper_limit     <= logrid_pkg::RST_UPPER_LIMIT;
        end else if (cfg_wr) begin
            case (cfg_idx)
                logrid_pkg::CFG_GRID_WIDTH:      r_grid_width      <= pwdata[8:0];
                logrid_pkg::CFG_GRID_HEIGHT:     r_grid_height     <= pwdata[8:0];
                logrid_pkg::CFG_KNOWN_THRESHOLD: r_known_threshold <= pwdata[14:0];
                logrid_pkg::CFG_FREE_STEP:       r_free_step       <= pwdata[15:0];
                logrid_pkg::CFG_OCCUPIED_STEP:   r_occupied_step   <= pwdata[14:0];
                logrid_pkg::CFG_LOWER_LIMIT:     r_lower_limit     <= pwdata[15:0];
                logrid_pkg::CFG_UPPER_LIMIT:     r_upper_limit     <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            logrid_pkg::CFG_GRID_WIDTH:      prdata = {23'd0, r_grid_width};
            logrid_pkg::CFG_GRID_HEIGHT:     prdata = {23'd0, r_grid_height};
            logrid_pkg::CFG_KNOWN_THRESHOLD: prdata = {17'd0, r_known_threshold};
            logrid_pkg::CFG_FREE_STEP:       prdata = {16'd0, r_free_step};
            logrid_pkg::CFG_OCCUPIED_STEP:   prdata = {17'd0, r_occupied_step};
            logrid_pkg::CFG_LOWER_LIMIT:     prdata = {16'd0, r_lower_limit};
            logrid_pkg::CFG_UPPER_LIMIT:     prdata = {16'd0, r_upper_limit};
            default:                         prdata = '0;
        endcase
    end

    // ---------------- cell address from the request ----------------
    logic [CWW-1:0] w_eff;
    logic [CWH-1:0] h_eff;
    logic           req_inside;
    logic [PW-1:0]  row_base;
    logic [IW-1:0]  idx_full;

    assign w_eff = (CWW'(r_grid_width) > CWW'(MAX_WIDTH)) ? CWW'(MAX_WIDTH)
                                                          : CWW'(r_grid_width);
    assign h_eff = (CWH'(r_grid_height) > CWH'(MAX_HEIGHT)) ? CWH'(MAX_HEIGHT)
                                                            : CWH'(r_grid_height);

    assign req_inside = !i_req.cell_x[15] && !i_req.cell_y[15]
                     && (CMPW'(i_req.cell_x[14:0]) < CMPW'(w_eff))
                     && (CMPW'(i_req.cell_y[14:0]) < CMPW'(h_eff));

    // row * width + column; below width*height when inside, so no wrap
    assign row_base = PW'(i_req.cell_y[YB-1:0]) * PW'(w_eff);
    assign idx_full = IW'(row_base) + IW'(i_req.cell_x[XB-1:0]);

    // ---------------- control ----------------
    logrid_pkg::t_state r_state, n_state;
    logic [AW-1:0]      r_clr_addr;
    logic               r_out_valid;

    logic               accept;
    logic               out_free;
    logic               mem_we;
    logic [AW-1:0]      mem_wa;
    logic [LB:0]        mem_wd;
    logic               out_load;

    // item registers
    logrid_pkg::t_op    r_op;
    logic               r_inside;
    logic [AW-1:0]      r_idx;
    logic               r_prior_occ;
    logic [14:0]        r_strength;
    logic               r_unk_occ;

    // memory: {observed, log-odds}
    logic [LB:0]        mem [CELLS];
    logic [LB:0]        r_rd;

    assign i_req.ready = (r_state == logrid_pkg::ST_IDLE);
    assign accept      = i_req.valid && i_req.ready;
    assign out_free    = !r_out_valid || o_rsp.ready;

    // ---------------- modify ----------------
    logic signed [LB-1:0] old_lo;
    logic                 old_obs;
    logic signed [EW-1:0] old_e, step_e, prior_e, cand, c1, c2, c3, c4;
    logic signed [EW-1:0] lower_e, upper_e, thr_e, res_e;
    logic                 is_prior, is_update, wr_cell, res_obs, perr;
    logrid_pkg::t_occ_state res_state;
    logic                 res_bin;

    assign old_lo  = r_rd[LB-1:0];
    assign old_obs = r_rd[LB];
    assign old_e   = EW'(old_lo);
    assign lower_e = EW'(r_lower_limit);
    assign upper_e = EW'(r_upper_limit);
    assign thr_e   = EW'(signed'({1'b0, r_known_threshold}));

    assign is_prior  = (r_op == logrid_pkg::OP_PRIOR);
    assign is_update = (r_op == logrid_pkg::OP_FREE) || (r_op == logrid_pkg::OP_OCCUPIED);
    assign step_e    = (r_op == logrid_pkg::OP_OCCUPIED)
                     ? EW'(signed'({1'b0, r_occupied_step})) : EW'(r_free_step);
    assign prior_e   = r_prior_occ ? EW'(signed'({1'b0, r_strength}))
                                   : -EW'(signed'({1'b0, r_strength}));
    assign cand      = is_prior ? prior_e : old_e + step_e;

    // lower limit first, so a crossed upper limit wins; then the store range
    assign c1 = (cand < lower_e) ? lower_e : cand;
    assign c2 = (c1 > upper_e)   ? upper_e : c1;
    assign c3 = (c2 < SMIN)      ? SMIN    : c2;
    assign c4 = (c3 > SMAX)      ? SMAX    : c3;

    assign wr_cell = r_inside && (is_update || (is_prior && (r_strength != 15'd0)));
    assign perr    = is_prior && (!r_inside || (r_strength == 15'd0));
    assign res_obs = r_inside && (wr_cell || old_obs);
    assign res_e   = !r_inside ? '0 : (wr_cell ? c4 : old_e);

    always_comb begin
        if (!res_obs) begin
            res_state = logrid_pkg::CS_UNKNOWN;
        end else if (res_e >= thr_e) begin
            res_state = logrid_pkg::CS_OCCUPIED;
        end else begin
            res_state = logrid_pkg::CS_FREE;
        end
    end

    assign res_bin = (res_state == logrid_pkg::CS_OCCUPIED)
                  || ((res_state == logrid_pkg::CS_UNKNOWN) && r_unk_occ);

    // ---------------- state machine ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= logrid_pkg::ST_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == logrid_pkg::ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        n_state  = r_state;
        mem_we   = 1'b0;
        mem_wa   = r_idx;
        mem_wd   = {1'b1, c4[LB-1:0]};
        out_load = 1'b0;
        case (r_state)
            logrid_pkg::ST_CLEAR: begin
                mem_we = 1'b1;
                mem_wa = r_clr_addr;
                mem_wd = '0;
                if (r_clr_addr == AW'(CELLS - 1)) begin
                    n_state = logrid_pkg::ST_IDLE;
                end
            end
            logrid_pkg::ST_IDLE: begin
                if (accept) begin
                    n_state = logrid_pkg::ST_READ;
                end
            end
            logrid_pkg::ST_READ: begin
                n_state = logrid_pkg::ST_MODIFY;
            end
            logrid_pkg::ST_MODIFY: begin
                // hold the item until the result register can take it
                if (out_free) begin
                    mem_we   = wr_cell;
                    out_load = 1'b1;
                    n_state  = logrid_pkg::ST_IDLE;
                end
            end
            default: n_state = logrid_pkg::ST_CLEAR;
        endcase
    end

    // ---------------- item and result registers ----------------
    logic               r_res_inside, r_res_obs, r_res_bin, r_res_perr;
    logic signed [15:0] r_res_lo;
    logic [1:0]         r_res_state;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op        <= logrid_pkg::t_op'(i_req.op);
            r_inside    <= req_inside;
            r_idx       <= idx_full[AW-1:0];
            r_prior_occ <= i_req.prior_occupied;
            r_strength  <= i_req.prior_strength;
            r_unk_occ   <= i_req.unknown_as_occupied;
        end
        if (out_load) begin
            r_res_inside <= r_inside;
            r_res_obs    <= res_obs;
            r_res_lo     <= res_e[15:0];
            r_res_state  <= res_state;
            r_res_bin    <= res_bin;
            r_res_perr   <= perr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (r_state == logrid_pkg::ST_READ) begin
            r_rd <= mem[r_idx];
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.inside_res    = r_res_inside;
    assign o_rsp.observed      = r_res_obs;
    assign o_rsp.cell_log_odds = r_res_lo;
    assign o_rsp.occ_state     = r_res_state;
    assign o_rsp.binary_state  = r_res_bin;
    assign o_rsp.prior_error   = r_res_perr;

endmodule

`default_nettype wire

FILE: sv/logrid_chk.sv
`default_nettype none
`include "assert_macros.svh"

module logrid_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        i_in_ready,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic        i_inside,
    input wire logic        i_observed,
    input wire logic [15:0] i_log_odds,
    input wire logic [1:0]  i_occ_state,
    input wire logic        i_binary,
    input wire logic        i_perr
);

    logic        in_acc;
    logic        out_stall;
    logic        blank;
    logic        known;
    logic [21:0] rsp_bits;

    assign in_acc    = i_in_valid && i_in_ready;
    assign out_stall = i_out_valid && !i_out_ready;
    assign blank     = !i_observed && (i_log_odds == 16'd0)
                    && (i_occ_state == logrid_pkg::CS_UNKNOWN);
    assign known     = (i_occ_state != logrid_pkg::CS_UNKNOWN);
    assign rsp_bits  = {i_inside, i_observed, i_log_odds, i_occ_state, i_binary, i_perr};

    // a stalled result holds
    `LOGRID_ASSERT(a_rsp_hold, i_clk, i_rst_n, out_stall |=> i_out_valid && $stable(rsp_bits))

    // a cell outside the grid reads as unobserved zero
    `LOGRID_ASSERT(a_outside_blank, i_clk, i_rst_n, i_out_valid && !i_inside |-> blank)

    // only observed cells carry a known state
    `LOGRID_ASSERT_NEVER(a_state_obs, i_clk, i_rst_n, i_out_valid && (i_observed != known))

    // occupied always reports binary occupied
    `LOGRID_ASSERT(a_occ_binary, i_clk, i_rst_n, i_out_valid && (i_occ_state == logrid_pkg::CS_OCCUPIED) |-> i_binary)

    // one item in flight: no accept right after an accept
    `LOGRID_ASSERT(a_one_item, i_clk, i_rst_n, in_acc |=> !i_in_ready)

endmodule

bind log_odds_occupancy_grid_unit logrid_chk u_logrid_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_req.valid),
    .i_in_ready   (i_req.ready),
    .i_out_valid  (o_rsp.valid),
    .i_out_ready  (o_rsp.ready),
    .i_inside     (o_rsp.inside_res),
    .i_observed   (o_rsp.observed),
    .i_log_odds   (o_rsp.cell_log_odds),
    .i_occ_state  (o_rsp.occ_state),
    .i_binary     (o_rsp.binary_state),
    .i_perr       (o_rsp.prior_error)
);

`default_nettype wire

FILE: bench/log_odds_occupancy_grid_unit_tb.sv
`timescale 1ns / 1ps

module log_odds_occupancy_grid_unit_tb;

    typedef struct {
        logrid_pkg::t_op    op;
        logic signed [15:0] cell_x;
        logic signed [15:0] cell_y;
        logic               prior_occupied;
        logic [14:0]        prior_strength;
        logic               unknown_as_occupied;
    } t_cell_req;

    typedef struct {
        logic                   inside_res;
        logic                   observed;
        logic signed [15:0]     cell_log_odds;
        logrid_pkg::t_occ_state occ_state;
        logic                   binary_state;
        logic                   prior_error;
    } t_cell_result;

    localparam int CELLS = 256 * 256;

    logic                              i_clk;
    logic                              i_rst_n;
    logic                              psel;
    logic                              penable;
    logic                              pwrite;
    logic [logrid_pkg::CFG_ADDR_W-1:0] paddr;
    logic [logrid_pkg::CFG_DATA_W-1:0] pwdata;
    logic [logrid_pkg::CFG_DATA_W-1:0] prdata;
    logic                              pready;

    logrid_req_if req_bus ();
    logrid_rsp_if rsp_bus ();

    log_odds_occupancy_grid_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Shadow of the configuration registers
    logic [8:0]         cfg_width     = logrid_pkg::RST_GRID_WIDTH;
    logic [8:0]         cfg_height    = logrid_pkg::RST_GRID_HEIGHT;
    logic [14:0]        cfg_threshold = logrid_pkg::RST_KNOWN_THRESHOLD;
    logic signed [15:0] cfg_free_step = logrid_pkg::RST_FREE_STEP;
    logic [14:0]        cfg_occ_step  = logrid_pkg::RST_OCCUPIED_STEP;
    logic signed [15:0] cfg_lower     = logrid_pkg::RST_LOWER_LIMIT;
    logic signed [15:0] cfg_upper     = logrid_pkg::RST_UPPER_LIMIT;

    // Shadow of the cell stores, flat index row * width + column
    bit signed [15:0] odds_mem [CELLS];
    bit               seen_mem [CELLS];

    t_cell_req    pending_reqs [$];
    t_cell_result expected_cells [$];
    t_cell_req    next_req;
    int           issued_count   = 0;
    int           accepted_count = 0;
    int           fail_count     = 0;
    int           send_gap       = 0;
    int           stall_left     = 0;
    bit           idling_on      = 1;
    bit           req_taken      = 0;

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    function automatic int used_width();
        return (cfg_width > 9'd256) ? 256 : int'(cfg_width);
    endfunction

    function automatic int used_height();
        return (cfg_height > 9'd256) ? 256 : int'(cfg_height);
    endfunction

    function automatic t_cell_result apply_cell_op(t_cell_req r);
        t_cell_result res;
        int           w;
        int           h;
        int           xi;
        int           yi;
        int           idx;
        int           v;
        bit           in_grid;
        bit           do_write;
        w  = used_width();
        h  = used_height();
        xi = r.cell_x;
        yi = r.cell_y;
        in_grid  = (xi >= 0) && (yi >= 0) && (xi < w) && (yi < h);
        idx      = in_grid ? (yi * w + xi) : 0;
        do_write = 1'b0;
        v        = 0;
        res.inside_res    = in_grid;
        res.observed      = 1'b0;
        res.cell_log_odds = '0;
        res.occ_state     = logrid_pkg::CS_UNKNOWN;
        res.prior_error   = 1'b0;
        if (r.op == logrid_pkg::OP_PRIOR) begin
            if (!in_grid || r.prior_strength == 15'd0) begin
                res.prior_error = 1'b1;
            end else begin
                v = r.prior_occupied ? int'(r.prior_strength) : -int'(r.prior_strength);
                do_write = 1'b1;
            end
        end else if (r.op != logrid_pkg::OP_QUERY && in_grid) begin
            v = int'(odds_mem[idx]) +
                ((r.op == logrid_pkg::OP_OCCUPIED) ? int'(cfg_occ_step)
                                                   : int'(cfg_free_step));
            do_write = 1'b1;
        end
        if (do_write) begin
            // lower bound first, so the upper limit wins when they cross
            if (v < int'(cfg_lower)) v = int'(cfg_lower);
            if (v > int'(cfg_upper)) v = int'(cfg_upper);
            odds_mem[idx] = v[15:0];
            seen_mem[idx] = 1'b1;
        end
        if (in_grid) begin
            res.observed      = seen_mem[idx];
            res.cell_log_odds = odds_mem[idx];
            if (seen_mem[idx])
                res.occ_state = (int'(odds_mem[idx]) >= int'(cfg_threshold)) ?
                                logrid_pkg::CS_OCCUPIED : logrid_pkg::CS_FREE;
        end
        res.binary_state = (res.occ_state == logrid_pkg::CS_OCCUPIED) ||
                           (res.occ_state == logrid_pkg::CS_UNKNOWN &&
                            r.unknown_as_occupied);
        return res;
    endfunction

    task automatic check_field(string field_name, logic signed [31:0] exp_v,
                               logic signed [31:0] act_v);
        if (act_v !== exp_v) begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, field_name, exp_v, act_v);
        end
    endtask

    // Predict on accepted requests, then check the accepted response
    always @(posedge i_clk) begin
        t_cell_req    acc;
        t_cell_result exp_c;
        req_taken = i_rst_n && req_bus.valid && req_bus.ready;
        if (req_taken) begin
            acc.op                  = logrid_pkg::t_op'(req_bus.op);
            acc.cell_x              = req_bus.cell_x;
            acc.cell_y              = req_bus.cell_y;
            acc.prior_occupied      = req_bus.prior_occupied;
            acc.prior_strength      = req_bus.prior_strength;
            acc.unknown_as_occupied = req_bus.unknown_as_occupied;
            expected_cells.insert(expected_cells.size(), apply_cell_op(acc));
            accepted_count++;
        end
        if (i_rst_n && rsp_bus.valid && rsp_bus.ready) begin
            if (expected_cells.size() == 0) begin
                fail_count++;
                $display("%0t: unexpected transaction, expected none, actual log-odds %0d",
                         $time, rsp_bus.cell_log_odds);
            end else begin
                exp_c = expected_cells.pop_front();
                check_field("inside_res", 32'(exp_c.inside_res), 32'(rsp_bus.inside_res));
                check_field("observed", 32'(exp_c.observed), 32'(rsp_bus.observed));
                check_field("cell_log_odds", 32'(exp_c.cell_log_odds),
                            32'(rsp_bus.cell_log_odds));
                check_field("occ_state", 32'(exp_c.occ_state), 32'(rsp_bus.occ_state));
                check_field("binary_state", 32'(exp_c.binary_state),
                            32'(rsp_bus.binary_state));
                check_field("prior_error", 32'(exp_c.prior_error), 32'(rsp_bus.prior_error));
            end
        end
    end

    // Request driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            req_bus.valid <= 1'b0;
        end else if (req_bus.valid && !req_taken) begin
            // hold until taken
        end else if (send_gap > 0) begin
            send_gap--;
            req_bus.valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
            next_req = pending_reqs.pop_front();
            req_bus.valid               <= 1'b1;
            req_bus.op                  <= next_req.op;
            req_bus.cell_x              <= next_req.cell_x;
            req_bus.cell_y              <= next_req.cell_y;
            req_bus.prior_occupied      <= next_req.prior_occupied;
            req_bus.prior_strength      <= next_req.prior_strength;
            req_bus.unknown_as_occupied <= next_req.unknown_as_occupied;
            if (idling_on && $urandom_range(0, 3) == 0)
                send_gap = int'($urandom_range(1, 11));
        end else begin
            req_bus.valid <= 1'b0;
        end
    end

    // Response backpressure
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            rsp_bus.ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
        end else begin
            rsp_bus.ready <= 1'b1;
            if (idling_on && $urandom_range(0, 4) == 0)
                stall_left = int'($urandom_range(1, 11));
        end
    end

    task automatic queue_req(logrid_pkg::t_op op, int x, int y, bit pocc, int strength,
                             bit unk);
        t_cell_req r;
        r.op                  = op;
        r.cell_x              = x[15:0];
        r.cell_y              = y[15:0];
        r.prior_occupied      = pocc;
        r.prior_strength      = strength[14:0];
        r.unknown_as_occupied = unk;
        pending_reqs.insert(pending_reqs.size(), r);
        issued_count++;
    endtask

    task automatic queue_random(int count);
        int w;
        int h;
        int x;
        int y;
        int pick;
        int s;
        w = used_width();
        h = used_height();
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                // small hot area so cells get hit repeatedly
                x = $urandom_range(0, ((w < 6) ? ((w == 0) ? 1 : w) : 6) - 1);
                y = $urandom_range(0, ((h < 6) ? ((h == 0) ? 1 : h) : 6) - 1);
            end else if (pick < 80) begin
                x = $urandom_range(0, ((w == 0) ? 1 : w) - 1);
                y = $urandom_range(0, ((h == 0) ? 1 : h) - 1);
            end else if (pick < 90) begin
                x = $urandom_range(0, 1) ? -1 : w;
                y = $urandom_range(0, ((h == 0) ? 1 : h) - 1);
                if ($urandom_range(0, 1)) begin
                    y = x;
                    x = $urandom_range(0, ((w == 0) ? 1 : w) - 1);
                end
            end else begin
                x = $signed($urandom_range(0, 16'hFFFF) - 32768);
                y = $signed($urandom_range(0, 16'hFFFF) - 32768);
            end
            case ($urandom_range(0, 9))
                0:       s = 0;
                1:       s = 32767;
                2, 3, 4, 5: s = $urandom_range(1, 600);
                default: s = $urandom_range(0, 32767);
            endcase
            queue_req(logrid_pkg::t_op'(2'($urandom_range(0, 3))), x, y,
                      1'($urandom_range(0, 1)), s, 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        while (pending_reqs.size() != 0 || accepted_count != issued_count ||
               expected_cells.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic cfg_write(logrid_pkg::t_cfg_reg reg_idx, logic [31:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (reg_idx)
            logrid_pkg::CFG_GRID_WIDTH:      cfg_width     = value[8:0];
            logrid_pkg::CFG_GRID_HEIGHT:     cfg_height    = value[8:0];
            logrid_pkg::CFG_KNOWN_THRESHOLD: cfg_threshold = value[14:0];
            logrid_pkg::CFG_FREE_STEP:       cfg_free_step = value[15:0];
            logrid_pkg::CFG_OCCUPIED_STEP:   cfg_occ_step  = value[14:0];
            logrid_pkg::CFG_LOWER_LIMIT:     cfg_lower     = value[15:0];
            logrid_pkg::CFG_UPPER_LIMIT:     cfg_upper     = value[15:0];
            default: ;
        endcase
    endtask

    task automatic set_grid(int w, int h, int thr, int fstep, int ostep, int lo, int hi);
        cfg_write(logrid_pkg::CFG_GRID_WIDTH, w);
        cfg_write(logrid_pkg::CFG_GRID_HEIGHT, h);
        cfg_write(logrid_pkg::CFG_KNOWN_THRESHOLD, thr);
        cfg_write(logrid_pkg::CFG_FREE_STEP, fstep);
        cfg_write(logrid_pkg::CFG_OCCUPIED_STEP, ostep);
        cfg_write(logrid_pkg::CFG_LOWER_LIMIT, lo);
        cfg_write(logrid_pkg::CFG_UPPER_LIMIT, hi);
    endtask

    initial begin
        i_rst_n                     = 1'b0;
        psel                        = 1'b0;
        penable                     = 1'b0;
        pwrite                      = 1'b0;
        paddr                       = '0;
        pwdata                      = '0;
        req_bus.valid               = 1'b0;
        req_bus.op                  = logrid_pkg::OP_QUERY;
        req_bus.cell_x              = '0;
        req_bus.cell_y              = '0;
        req_bus.prior_occupied      = 1'b0;
        req_bus.prior_strength      = '0;
        req_bus.unknown_as_occupied = 1'b0;
        rsp_bus.ready               = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset configuration, directed corners
        queue_req(logrid_pkg::OP_QUERY, 0, 0, 0, 0, 0);
        queue_req(logrid_pkg::OP_QUERY, 0, 0, 0, 0, 1);
        queue_req(logrid_pkg::OP_FREE, 0, 0, 0, 0, 0);
        // climbs into the upper clamp
        repeat (6) queue_req(logrid_pkg::OP_OCCUPIED, 255, 255, 0, 0, 0);
        queue_req(logrid_pkg::OP_FREE, -1, 0, 0, 0, 0);
        queue_req(logrid_pkg::OP_OCCUPIED, 256, 3, 1, 0, 1);
        queue_req(logrid_pkg::OP_QUERY, 3, -32768, 0, 0, 1);
        queue_req(logrid_pkg::OP_PRIOR, 32767, 32767, 1, 100, 0);
        queue_req(logrid_pkg::OP_PRIOR, 10, 10, 1, 0, 1);          // zero strength
        queue_req(logrid_pkg::OP_PRIOR, 5, 5, 1, 32767, 0);
        queue_req(logrid_pkg::OP_PRIOR, 6, 5, 0, 32767, 0);
        queue_req(logrid_pkg::OP_FREE, 6, 5, 0, 0, 1);
        queue_req(logrid_pkg::OP_PRIOR, 7, 5, 1, 1, 0);
        queue_req(logrid_pkg::OP_PRIOR, 8, 5, 1, 256, 0);          // exactly at threshold
        queue_req(logrid_pkg::OP_QUERY, -32768, 32767, 0, 0, 0);
        queue_req(logrid_pkg::OP_PRIOR, 0, 255, 0, 16384, 1);
        queue_req(logrid_pkg::OP_QUERY, 255, 255, 0, 0, 0);
        queue_req(logrid_pkg::OP_OCCUPIED, 0, 0, 0, 0, 0);
        queue_req(logrid_pkg::OP_PRIOR, -1, -1, 0, 0, 1);
        queue_req(logrid_pkg::OP_QUERY, 255, 0, 0, 0, 1);
        queue_random(300);
        wait_drained();

        // Tiny grid, widest steps and limits
        set_grid(5, 3, 1, -32768, 32767, -32768, 32767);
        queue_random(250);
        wait_drained();

        // Single column, top threshold, non-negative free step, zero occupied step
        set_grid(1, 256, 32767, 77, 0, -300, 300);
        queue_random(250);
        wait_drained();

        // Crossed limits: everything written lands on the upper limit
        set_grid(16, 16, 0, -102, 218, 500, -500);
        queue_random(250);
        wait_drained();

        // Zero width, oversize height: nothing is inside
        set_grid(0, 511, 256, -102, 218, -1280, 1280);
        queue_random(100);
        wait_drained();

        // Oversize width taken as the maximum
        set_grid(511, 2, 128, -200, 300, -2000, 2000);
        queue_random(150);
        wait_drained();

        set_grid(256, 256, 256, -102, 218, -1280, 1280);
        idling_on = 1'b0;
        queue_random(200);
        wait_drained();
        repeat (8) @(negedge i_clk);

        if (fail_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
